### rtl/dbfm_pkg.sv
// ----------------------------------------------------------------------------
// dbfm_pkg
// Shared types and constants of the double-buffer frame manager.
// ----------------------------------------------------------------------------
package dbfm_pkg;

    localparam int CMD_W      = 3;
    localparam int LEN_W      = 24;
    localparam int SEQ_W      = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 64;   // 57 bits of fields, padded to bytes
    localparam int OUT_DATA_W = 184;  // 178 bits of fields, padded to bytes

    localparam logic [CMD_W-1:0] CMD_ACQUIRE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_COMMIT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DROP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET_READY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DROP_OLDEST     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_BYTES = 1'd1;

    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 24'd1024;

    typedef enum logic [1:0] {
        BUF_EMPTY   = 2'd0,
        BUF_WRITING = 2'd1,
        BUF_READY   = 2'd2,
        BUF_READING = 2'd3
    } buf_status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // apply the held request and load the result register
    } dbfm_ctrl_t;

endpackage

### rtl/dbfm_ctrl.sv
// ----------------------------------------------------------------------------
// dbfm_ctrl
// Sequencer: takes a request, runs it through the datapath and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module dbfm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output dbfm_pkg::dbfm_ctrl_t ctl
);

    dbfm_pkg::ctrl_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  exec_ok;

    // the result register is free when empty or being taken this cycle
    assign exec_ok = (state_reg == dbfm_pkg::ST_EXEC) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dbfm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = dbfm_pkg::ST_EXEC;
                end
            end
            dbfm_pkg::ST_EXEC:
            begin
                if (exec_ok)
                begin
                    state_next = dbfm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dbfm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = (state_reg == dbfm_pkg::ST_IDLE);
        ctl.load       = s_tready && s_tvalid;
        ctl.exec       = exec_ok;
        out_valid_next = out_valid_reg;
        if (exec_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        m_tvalid = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dbfm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/dbfm_datapath.sv
// ----------------------------------------------------------------------------
// dbfm_datapath
// Buffer status, stored frame info, counters, configuration and the
// request and result registers.
// ----------------------------------------------------------------------------
module dbfm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dbfm_pkg::dbfm_ctrl_t                ctl,
    input  logic [dbfm_pkg::CMD_W-1:0]          in_cmd,
    input  logic [dbfm_pkg::IN_DATA_W-1:0]      in_data,
    input  logic                                cfg_we,
    input  logic [dbfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dbfm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [dbfm_pkg::OUT_DATA_W-1:0]     out_data
);

    // held request
    logic [dbfm_pkg::CMD_W-1:0] cmd_reg;
    logic [dbfm_pkg::LEN_W-1:0] flen_reg;
    logic [dbfm_pkg::SEQ_W-1:0] fseq_reg;
    logic                       tok_reg;

    // configuration
    logic                       drop_oldest_reg;
    logic [dbfm_pkg::LEN_W-1:0] max_bytes_reg;

    // buffer state
    dbfm_pkg::buf_status_t      status_reg [2];
    dbfm_pkg::buf_status_t      status_next [2];
    logic [dbfm_pkg::LEN_W-1:0] len_reg [2];
    logic [dbfm_pkg::LEN_W-1:0] len_next [2];
    logic [dbfm_pkg::SEQ_W-1:0] seq_reg [2];
    logic [dbfm_pkg::SEQ_W-1:0] seq_next [2];
    logic                       wr_idx_reg, wr_idx_next;
    logic [dbfm_pkg::CNT_W-1:0] ok_reg, ok_next;
    logic [dbfm_pkg::CNT_W-1:0] drop_reg, drop_next;
    logic [dbfm_pkg::CNT_W-1:0] bad_reg, bad_next;

    // result fields
    logic                       granted;
    logic                       buf_idx;
    logic [dbfm_pkg::LEN_W-1:0] cap;
    logic [dbfm_pkg::LEN_W-1:0] rlen;
    logic [dbfm_pkg::SEQ_W-1:0] rseq;
    logic [dbfm_pkg::LEN_W-1:0] cap_clamped;
    logic [dbfm_pkg::OUT_DATA_W-1:0] out_data_reg;

    assign cap_clamped = (max_bytes_reg < dbfm_pkg::MIN_FRAME_BYTES) ?
                         dbfm_pkg::MIN_FRAME_BYTES : max_bytes_reg;

    always_comb
    begin
        logic w;
        logic ok;
        status_next = status_reg;
        len_next    = len_reg;
        seq_next    = seq_reg;
        wr_idx_next = wr_idx_reg;
        ok_next     = ok_reg;
        drop_next   = drop_reg;
        bad_next    = bad_reg;
        granted     = 1'b0;
        buf_idx     = 1'b0;
        cap         = '0;
        rlen        = '0;
        rseq        = '0;
        w           = wr_idx_reg;
        ok          = 1'b1;
        unique case (cmd_reg)
            dbfm_pkg::CMD_ACQUIRE:
            begin
                if (status_reg[w] != dbfm_pkg::BUF_EMPTY &&
                    status_reg[~w] == dbfm_pkg::BUF_EMPTY)
                begin
                    w = ~w;
                end
                if (status_reg[w] != dbfm_pkg::BUF_EMPTY)
                begin
                    drop_next = drop_reg + 32'd1;
                    // reclaim a ready frame, buffer 0 first
                    if (drop_oldest_reg && status_reg[0] == dbfm_pkg::BUF_READY)
                    begin
                        w           = 1'b0;
                        len_next[0] = '0;
                    end
                    else if (drop_oldest_reg && status_reg[1] == dbfm_pkg::BUF_READY)
                    begin
                        w           = 1'b1;
                        len_next[1] = '0;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                if (ok)
                begin
                    wr_idx_next    = w;
                    status_next[w] = dbfm_pkg::BUF_WRITING;
                    granted        = 1'b1;
                    buf_idx        = w;
                    cap            = cap_clamped;
                end
            end
            dbfm_pkg::CMD_COMMIT:
            begin
                status_next[wr_idx_reg] = dbfm_pkg::BUF_READY;
                len_next[wr_idx_reg]    = flen_reg;
                seq_next[wr_idx_reg]    = fseq_reg;
                ok_next                 = ok_reg + 32'd1;
                wr_idx_next             = ~wr_idx_reg;
            end
            dbfm_pkg::CMD_DROP:
            begin
                bad_next = bad_reg + 32'd1;
                if (status_reg[wr_idx_reg] == dbfm_pkg::BUF_WRITING)
                begin
                    status_next[wr_idx_reg] = dbfm_pkg::BUF_EMPTY;
                    len_next[wr_idx_reg]    = '0;
                end
            end
            dbfm_pkg::CMD_GET_READY:
            begin
                if (status_reg[0] == dbfm_pkg::BUF_READY)
                begin
                    status_next[0] = dbfm_pkg::BUF_READING;
                    granted        = 1'b1;
                    buf_idx        = 1'b0;
                    rlen           = len_reg[0];
                    rseq           = seq_reg[0];
                end
                else if (status_reg[1] == dbfm_pkg::BUF_READY)
                begin
                    status_next[1] = dbfm_pkg::BUF_READING;
                    granted        = 1'b1;
                    buf_idx        = 1'b1;
                    rlen           = len_reg[1];
                    rseq           = seq_reg[1];
                end
            end
            dbfm_pkg::CMD_RELEASE:
            begin
                status_next[tok_reg] = dbfm_pkg::BUF_EMPTY;
                len_next[tok_reg]    = '0;
            end
            default:
            begin
                // unknown command: no change, refusal result
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_oldest_reg <= 1'b0;
            max_bytes_reg   <= dbfm_pkg::MIN_FRAME_BYTES;
            status_reg[0]   <= dbfm_pkg::BUF_EMPTY;
            status_reg[1]   <= dbfm_pkg::BUF_EMPTY;
            len_reg[0]      <= '0;
            len_reg[1]      <= '0;
            seq_reg[0]      <= '0;
            seq_reg[1]      <= '0;
            wr_idx_reg      <= 1'b0;
            ok_reg          <= '0;
            drop_reg        <= '0;
            bad_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dbfm_pkg::REG_DROP_OLDEST:     drop_oldest_reg <= cfg_data[0];
                    dbfm_pkg::REG_MAX_FRAME_BYTES: max_bytes_reg   <= cfg_data;
                    default:                       ;
                endcase
            end
            if (ctl.exec)
            begin
                status_reg <= status_next;
                len_reg    <= len_next;
                seq_reg    <= seq_next;
                wr_idx_reg <= wr_idx_next;
                ok_reg     <= ok_next;
                drop_reg   <= drop_next;
                bad_reg    <= bad_next;
            end
        end
    end

    // request and result payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= in_cmd;
            flen_reg <= in_data[23:0];
            fseq_reg <= in_data[55:24];
            tok_reg  <= in_data[56];
        end
        if (ctl.exec)
        begin
            out_data_reg <= {6'd0, bad_next, drop_next, ok_next, rseq, rlen, cap,
                             buf_idx, granted};
        end
    end

    assign out_data = out_data_reg;

endmodule

### rtl/double_buffer_frame_manager.sv
// ----------------------------------------------------------------------------
// double_buffer_frame_manager
// Ping-pong frame manager: tracks two frame buffers through free, writing,
// ready and reading, and counts committed, dropped and aborted frames.
//
//   channel   dir   width        contents
//   s_*       in    64 + 3 user  one request: command and its arguments
//   m_*       out   184          one result per request
//   cfg_*     in    1 + 24       register writes, no read-back
//
// Each request is captured first, then applied: the buffer state and
// counters are updated and the result register is loaded.
// A new request is taken while the previous result still waits in the
// result register; a stalled result holds back the update of the next one.
// Reset frees both buffers, clears stored info and counters, and sets the
// capacity to 1024 bytes with drop-oldest off.
// ----------------------------------------------------------------------------
module double_buffer_frame_manager (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [23:0] frame_length, [55:24] frame_seq, [56] release_token
    input  logic [dbfm_pkg::IN_DATA_W-1:0]      s_tdata,
    // [2:0] command
    input  logic [dbfm_pkg::CMD_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] granted, [1] buffer_index, [25:2] frame_capacity,
    // [49:26] ready_length, [81:50] ready_seq, [113:82] ok_count,
    // [145:114] drop_count, [177:146] bad_count
    output logic [dbfm_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [dbfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dbfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dbfm_pkg::dbfm_ctrl_t ctl;

    dbfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    dbfm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_cmd    (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata)
    );

endmodule
